// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the date difference block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: property does not hold");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/dd_pkg.sv -----
// Package with the types, constants and calendar tables of the date difference block.
`default_nettype none

package dd_pkg;

  // Field widths of the request and result words.
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned COUNT_W  = 22;
  localparam int unsigned SERIAL_W = 22;

  // Largest accepted year.
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // Largest count that the result word can carry.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Division of a 14-bit year by 100: multiply by RECIP_100, shift right by RECIP_SHIFT.
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned CENT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  // Days in a common year, the first and last month, and the month whose length depends on the leap rule.
  localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 22'd365;
  localparam logic [MONTH_W-1:0]  MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0]  MONTH_DEC     = 4'd12;

  // Request word: two dates and the include-end-day flag.
  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end_day;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               bad_date;
  } out_t;

  // Day number of one date together with its validity.
  typedef struct packed {
    logic                ok;
    logic [SERIAL_W-1:0] serial;
  } date_info_t;

  // Length of a month; zero for a month number outside the calendar.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year that come before the first of a month.
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] days;
    case (m)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dd_serial.sv -----
// Validity check and closed-form day number of one Gregorian date.
`default_nettype none

module dd_serial (
  input  wire logic [dd_pkg::YEAR_W-1:0]  year_i,
  input  wire logic [dd_pkg::MONTH_W-1:0] month_i,
  input  wire logic [dd_pkg::DAY_W-1:0]   day_i,
  output dd_pkg::date_info_t              info_o
);

  logic [dd_pkg::PROD_W-1:0]   y_prod;
  logic [dd_pkg::CENT_W-1:0]   y_cent;
  logic [dd_pkg::YEAR_W-1:0]   y_rem;
  logic                        leap;
  logic [dd_pkg::YEAR_W-1:0]   p;
  logic [dd_pkg::PROD_W-1:0]   p_prod;
  logic [dd_pkg::CENT_W-1:0]   p_cent;
  logic [dd_pkg::SERIAL_W-1:0] base;
  logic [dd_pkg::DAY_W-1:0]    mlen;
  logic [8:0]                  mstart;
  logic                        after_feb;
  logic                        year_ok;
  logic                        month_ok;
  logic                        day_ok;

  // Century of the year itself, by reciprocal multiplication, for the leap rule.
  assign y_prod = dd_pkg::PROD_W'(year_i) * dd_pkg::PROD_W'(dd_pkg::RECIP_100);
  assign y_cent = y_prod[dd_pkg::PROD_W-1:dd_pkg::RECIP_SHIFT];
  assign y_rem  = year_i - dd_pkg::YEAR_W'(y_cent) * dd_pkg::YEAR_W'(100);

  // Leap when divisible by 4 and not by 100, or divisible by 400.
  assign leap = (year_i[1:0] == 2'b00) && ((y_rem != '0) || (y_cent[1:0] == 2'b00));

  // Whole years before this one, with their leap days.
  assign p      = year_i - dd_pkg::YEAR_W'(1);
  assign p_prod = dd_pkg::PROD_W'(p) * dd_pkg::PROD_W'(dd_pkg::RECIP_100);
  assign p_cent = p_prod[dd_pkg::PROD_W-1:dd_pkg::RECIP_SHIFT];
  assign base   = dd_pkg::SERIAL_W'(p) * dd_pkg::DAYS_PER_YEAR
                + dd_pkg::SERIAL_W'(p[dd_pkg::YEAR_W-1:2])
                - dd_pkg::SERIAL_W'(p_cent)
                + dd_pkg::SERIAL_W'(p_cent[dd_pkg::CENT_W-1:2]);

  // Month length and the days of the year before the month.
  assign mlen      = dd_pkg::month_len(month_i, leap);
  assign mstart    = dd_pkg::month_start(month_i);
  assign after_feb = leap && (month_i > dd_pkg::MONTH_FEB);

  // Range checks on each field.
  assign year_ok  = (year_i != '0) && (year_i <= dd_pkg::YEAR_MAX);
  assign month_ok = (month_i >= dd_pkg::MONTH_JAN) && (month_i <= dd_pkg::MONTH_DEC);
  assign day_ok   = (day_i != '0) && (day_i <= mlen);

  // Day number, 0001-01-01 being day one.
  assign info_o.ok     = year_ok && month_ok && day_ok;
  assign info_o.serial = base + dd_pkg::SERIAL_W'(mstart)
                       + dd_pkg::SERIAL_W'(after_feb) + dd_pkg::SERIAL_W'(day_i);

endmodule

`default_nettype wire

// ----- hdl/date_difference_in_days_top.sv -----
// Top level of the date difference block: request register, day numbers, count, result register.
//
//   Port group   Direction  Handshake             Word
//   request      in         start & !busy         req_i  (dd_pkg::in_t)
//   result       out        done_o, one cycle     res_o  (dd_pkg::out_t)
//
// A request is taken at every clock edge at which start is high; busy is never raised.
// The request passes the request register and the day-number registers; the result register then drives the
// result for one cycle, and a new word can enter in every cycle.
// The stages are: request register, day numbers of both dates, count and result register.
// Reset clears the stage valid bits only; the data registers keep whatever they hold.
// The receiver cannot stall, so no word ever waits in the pipeline.
`default_nettype none
`include "assert_macros.svh"

module date_difference_in_days_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  output logic        busy,
  input  wire dd_pkg::in_t req_i,
  output logic        done_o,
  output dd_pkg::out_t res_o
);

  dd_pkg::in_t        req_q;
  logic               vld_a_q;
  dd_pkg::date_info_t start_info;
  dd_pkg::date_info_t end_info;
  dd_pkg::date_info_t start_q;
  dd_pkg::date_info_t end_q;
  logic               inc_q;
  logic               vld_b_q;
  logic [dd_pkg::SERIAL_W-1:0] diff;
  logic [dd_pkg::COUNT_W:0]    count_sum;
  dd_pkg::out_t       res_d;
  dd_pkg::out_t       res_q;
  logic               done_q;

  assign busy = 1'b0;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_a_q <= start && !busy;
      vld_b_q <= vld_a_q;
      done_q  <= vld_b_q;
    end
  end

  // Request register.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // Day numbers of both dates.
  dd_serial u_start_serial (
    .year_i  (req_q.start_year),
    .month_i (req_q.start_month),
    .day_i   (req_q.start_day),
    .info_o  (start_info)
  );

  dd_serial u_end_serial (
    .year_i  (req_q.end_year),
    .month_i (req_q.end_month),
    .day_i   (req_q.end_day),
    .info_o  (end_info)
  );

  always_ff @(posedge clk_i) begin
    if (vld_a_q) begin
      start_q <= start_info;
      end_q   <= end_info;
      inc_q   <= req_q.include_end_day;
    end
  end

  // Count of days, saturated to the width of the result word.
  assign diff      = (start_q.serial < end_q.serial) ? (end_q.serial - start_q.serial) : '0;
  assign count_sum = (dd_pkg::COUNT_W+1)'(diff) + (dd_pkg::COUNT_W+1)'(inc_q);

  always_comb begin
    if (!(start_q.ok && end_q.ok)) begin
      res_d.day_count = '0;
      res_d.bad_date  = 1'b1;
    end else if (count_sum[dd_pkg::COUNT_W]) begin
      res_d.day_count = dd_pkg::COUNT_MAX;
      res_d.bad_date  = 1'b0;
    end else begin
      res_d.day_count = count_sum[dd_pkg::COUNT_W-1:0];
      res_d.bad_date  = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (vld_b_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every request taken gives its result, and no result comes without a request.
  `ASSERT_ALWAYS(a_req_gives_result, clk_i, rst_ni, (start && !busy) |=> ##2 done_o)
  `ASSERT_ALWAYS(a_result_has_req, clk_i, rst_ni, done_o |-> $past(start, 3))
  // A bad date always reports a zero count.
  `ASSERT_NEVER(a_bad_date_zero, clk_i, rst_ni, done_o && res_o.bad_date && (res_o.day_count != '0))

endmodule

`default_nettype wire
